// File: rtl/core/deq_pkg.sv
// shared constants and types for the double-ended queue unit
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // qualified operations broadcast to every cell
    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } t_deq_ops;

endpackage

// File: rtl/core/double_ended_queue_unit.sv
// top level of the double-ended queue unit: cell chain, command decode, result register
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   command | i_valid / o_ready  | i_cmd, i_value
//   result  | o_valid / i_ready  | o_popped_value, o_status, o_count,
//           |                    | o_front_value, o_back_value, o_is_empty
//
// one command per cycle while results are taken; its result word is registered and shows in the
// cycle after acceptance. the front of the deque always sits in cell 0 and the back in the last
// valid cell, so every push or pop is one shift or one local write across the chain.
// a command is taken whenever the result register is empty or drains in that cycle,
// so a stalled result holds the chain. reset is synchronous and active low; it clears
// the cell valid bits, the count and the result valid, with no clearing pass.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [CMD_W-1:0]             i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_popped_value,
    output logic [STATUS_W-1:0]          o_status,
    output logic [CNT_W-1:0]             o_count,
    output logic signed [DATA_WIDTH-1:0] o_front_value,
    output logic signed [DATA_WIDTH-1:0] o_back_value,
    output logic                         o_is_empty
);

    // cell chain signals
    logic [DATA_WIDTH-1:0] c_data       [DEPTH];
    logic                  c_valid      [DEPTH];
    logic [DATA_WIDTH-1:0] c_next_data  [DEPTH];
    logic                  c_next_valid [DEPTH];

    t_deq_ops ops;
    logic     accept;
    logic     full;
    logic     empty;
    t_status  status;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [DATA_WIDTH-1:0] cur_back;
    logic [DATA_WIDTH-1:0] new_back;
    logic [DATA_WIDTH-1:0] new_front;
    logic [DATA_WIDTH-1:0] popped;

    // result register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_popped;
    t_status               r_status;
    logic [CNT_W-1:0]      r_out_count;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;
    logic                  r_is_empty;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);

    // decode; refused pushes and pops never reach the cells
    always_comb begin
        ops     = '0;
        status  = ST_OK;
        n_count = r_count;
        case (i_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ops.add_front = accept && (i_cmd == CMD_PUSH_FRONT);
                    ops.add_back  = accept && (i_cmd == CMD_PUSH_BACK);
                    n_count       = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ops.take_front = accept && (i_cmd == CMD_POP_FRONT);
                    ops.take_back  = accept && (i_cmd == CMD_POP_BACK);
                    n_count        = r_count - CNT_W'(1);
                end
            end
            default: begin
                // query and unused codes leave everything alone
                status = ST_OK;
            end
        endcase
    end

    // the chain: cell 0 is the front, its left input is the pushed word
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic                  left_valid;
        logic [DATA_WIDTH-1:0] right_data;
        logic                  right_valid;

        if (g == 0) begin : g_first
            assign left_data  = i_value;
            assign left_valid = 1'b1;
        end else begin : g_mid_l
            assign left_data  = c_data[g-1];
            assign left_valid = c_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_data  = c_data[g+1];
            assign right_valid = c_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ops         (ops),
            .i_value       (i_value),
            .i_left_data   (left_data),
            .i_left_valid  (left_valid),
            .i_right_data  (right_data),
            .i_right_valid (right_valid),
            .o_data        (c_data[g]),
            .o_valid       (c_valid[g]),
            .o_next_data   (c_next_data[g]),
            .o_next_valid  (c_next_valid[g])
        );
    end

    // back word: the one valid cell whose right neighbor is empty, picked by and-or
    always_comb begin
        cur_back = c_data[DEPTH-1] & {DATA_WIDTH{c_valid[DEPTH-1]}};
        new_back = c_next_data[DEPTH-1] & {DATA_WIDTH{c_next_valid[DEPTH-1]}};
        for (int i = 0; i < DEPTH - 1; i++) begin
            cur_back = cur_back
                     | (c_data[i] & {DATA_WIDTH{c_valid[i] && !c_valid[i+1]}});
            new_back = new_back
                     | (c_next_data[i]
                        & {DATA_WIDTH{c_next_valid[i] && !c_next_valid[i+1]}});
        end
    end

    assign new_front = c_next_valid[0] ? c_next_data[0] : '0;

    always_comb begin
        popped = '0;
        if (ops.take_front) begin
            popped = c_data[0];
        end else if (ops.take_back) begin
            popped = cur_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped    <= popped;
            r_status    <= status;
            r_out_count <= n_count;
            r_front     <= new_front;
            r_back      <= new_back;
            r_is_empty  <= !c_next_valid[0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_count        = r_out_count;
    assign o_front_value  = r_front;
    assign o_back_value   = r_back;
    assign o_is_empty     = r_is_empty;

endmodule

// File: rtl/core/deq_cell.sv
// one storage cell of the deque shift chain
module deq_cell
    import deq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_deq_ops              i_ops,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_left_valid,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_next_data,
    output logic                  o_next_valid
);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ops.add_front) begin
            // everything moves one cell toward the back
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ops.take_front) begin
            // everything moves one cell toward the front
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ops.add_back) begin
            // first free cell takes the word
            if (!r_valid && i_left_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ops.take_back) begin
            // last occupied cell lets go
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data       = r_data;
    assign o_valid      = r_valid;
    assign o_next_data  = n_data;
    assign o_next_valid = n_valid;

endmodule

// File: bench/double_ended_queue_unit_test.sv
// self-checking testbench for the double-ended queue unit
module double_ended_queue_unit_test
    import deq_pkg::*;
();

    // command codes the package leaves unnamed: plain query and the spare codes
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_ITEMS   = 300;

    // one expected result word
    typedef struct {
        logic [DATA_WIDTH-1:0] popped;
        t_status               status;
        logic [CNT_W-1:0]      count;
        logic [DATA_WIDTH-1:0] front;
        logic [DATA_WIDTH-1:0] back;
        logic                  empty;
    } t_deq_result;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [CMD_W-1:0]             i_cmd   = '0;
    logic signed [DATA_WIDTH-1:0] i_value = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_popped_value;
    logic [STATUS_W-1:0]          o_status;
    logic [CNT_W-1:0]             o_count;
    logic signed [DATA_WIDTH-1:0] o_front_value;
    logic signed [DATA_WIDTH-1:0] o_back_value;
    logic                         o_is_empty;

    // own copy of the deque contents, front index and fill level
    logic [DATA_WIDTH-1:0] deq_slots [DEPTH];
    int                    deq_head  = 0;
    int                    deq_fill  = 0;

    t_deq_result pending_results [$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    double_ended_queue_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_is_empty     (o_is_empty)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** double_ended_queue_unit: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure, one decision per cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // apply one accepted command to the local deque and queue its result word
    task automatic apply_to_deque(input logic [CMD_W-1:0] cmd,
                                  input logic [DATA_WIDTH-1:0] value);
        t_deq_result r;
        r.popped = '0;
        r.status = ST_OK;
        r.front  = '0;
        r.back   = '0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (deq_fill == DEPTH) begin
                    r.status = ST_FULL;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    deq_head = (deq_head + DEPTH - 1) % DEPTH;
                    deq_slots[deq_head] = value;
                    deq_fill++;
                end else begin
                    deq_slots[(deq_head + deq_fill) % DEPTH] = value;
                    deq_fill++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (deq_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (cmd == CMD_POP_FRONT) begin
                    r.popped = deq_slots[deq_head];
                    deq_head = (deq_head + 1) % DEPTH;
                    deq_fill--;
                end else begin
                    r.popped = deq_slots[(deq_head + deq_fill - 1) % DEPTH];
                    deq_fill--;
                end
            end
            default: begin
                // query and spare codes leave the deque alone
            end
        endcase
        if (deq_fill != 0) begin
            r.front = deq_slots[deq_head];
            r.back  = deq_slots[(deq_head + deq_fill - 1) % DEPTH];
        end
        r.count = CNT_W'(deq_fill);
        r.empty = (deq_fill == 0);
        pending_results.insert(pending_results.size(), r);
    endtask

    function automatic void check_field(input string name,
                                        input logic [DATA_WIDTH-1:0] expected,
                                        input logic [DATA_WIDTH-1:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            fail_count++;
        end
    endfunction

    // result checker: every accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("popped_value", want.popped, o_popped_value);
                check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(o_status));
                check_field("count", DATA_WIDTH'(want.count), DATA_WIDTH'(o_count));
                check_field("front_value", want.front, o_front_value);
                check_field("back_value", want.back, o_back_value);
                check_field("is_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(o_is_empty));
            end
        end
    end

    // send one command word; valid stays high between back-to-back words
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_WIDTH-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        apply_to_deque(cmd, value);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [DATA_WIDTH-1:0] random_value();
        case ($urandom_range(15))
            0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    // pops and queries on the empty deque, spare codes with junk values
    task automatic test_empty_deque();
        send_word(CMD_QUERY, 32'h1234_5678);
        send_word(CMD_POP_FRONT, 32'hffff_ffff);
        send_word(CMD_POP_BACK, 32'h8000_0000);
        send_word(CMD_SPARE_LO, 32'h7fff_ffff);
        send_word(CMD_SPARE_HI, 32'hdead_beef);
    endtask

    // fill from both ends with extreme values, hit the full error, then pop each end
    task automatic test_fill_to_full();
        logic [DATA_WIDTH-1:0] patterns [16];
        patterns = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001,
                     32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_ffff,
                     32'hffff_0000, 32'h1357_9bdf, 32'heca8_6420, 32'hc0ff_ee00};
        for (int i = 0; i < 16; i++) begin
            send_word((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, patterns[i]);
        end
        send_word(CMD_PUSH_FRONT, 32'h1111_1111);
        send_word(CMD_PUSH_BACK, 32'h2222_2222);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
    endtask

    // bursts that lean toward filling or draining so both limits come up often
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int                    sent;
        int                    burst;
        int                    push_pct;
        int                    roll;
        logic [CMD_W-1:0]      cmd;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            burst    = $urandom_range(8, 40);
            push_pct = $urandom_range(1) ? 80 : 20;
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 10)
                    cmd = CMD_QUERY + CMD_W'($urandom_range(3));
                else if ($urandom_range(99) < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
                send_word(cmd, random_value());
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        // reset held low from the start, released once
        send_idle_pct = 25;
        recv_idle_pct = 71;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_deque();
        test_fill_to_full();
        test_random_traffic(25, 71);
        test_random_traffic(71, 25);
        test_random_traffic(0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("** double_ended_queue_unit: PASSED **");
        end else begin
            $display("** double_ended_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_unit.sv
bench/double_ended_queue_unit_test.sv
